@@ sv/assert_macros.svh @@
// Assertion helpers shared by the checker files.
// Clock clk_i and active-low reset rst_ni are assumed in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// cond must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ sv/c8x_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the instruction classifier for the CHIP-8 executor.
// No dependencies.
package c8x_pkg;

  localparam int unsigned MEM_BYTES   = 4096;
  localparam int unsigned MEM_AW      = 12;
  localparam int unsigned DEF_COLS    = 64;
  localparam int unsigned DEF_ROWS    = 32;
  localparam int unsigned DEF_STACK   = 16;
  localparam logic [11:0] PC_RESET    = 12'h200;
  localparam logic [15:0] FONT_BASE   = 16'h0050;

  localparam logic [2:0] FN_EXEC = 3'd0;
  localparam logic [2:0] FN_TICK = 3'd1;
  localparam logic [2:0] FN_MWR  = 3'd2;
  localparam logic [2:0] FN_MRD  = 3'd3;
  localparam logic [2:0] FN_SRD  = 3'd4;

  localparam logic [15:0] INS_CLS = 16'h00E0;
  localparam logic [15:0] INS_RET = 16'h00EE;

  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEI  = 4'h3;
  localparam logic [3:0] OP_SNEI = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDK  = 4'h6;
  localparam logic [3:0] OP_ADDK = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV  = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEYS = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [7:0] SUB_SKP  = 8'h9E;
  localparam logic [7:0] SUB_SKNP = 8'hA1;
  localparam logic [7:0] SUB_GDT  = 8'h07;
  localparam logic [7:0] SUB_KEY  = 8'h0A;
  localparam logic [7:0] SUB_SDT  = 8'h15;
  localparam logic [7:0] SUB_SST  = 8'h18;
  localparam logic [7:0] SUB_ADDI = 8'h1E;
  localparam logic [7:0] SUB_FONT = 8'h29;
  localparam logic [7:0] SUB_BCD  = 8'h33;
  localparam logic [7:0] SUB_STR  = 8'h55;
  localparam logic [7:0] SUB_LDR  = 8'h65;

  localparam logic [3:0] ALU_LD   = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  typedef enum logic [4:0] {
    K_NOP, K_IGN, K_CLS, K_RET, K_JP, K_CALL, K_SEI, K_SNEI,
    K_SER, K_LDK, K_ADDK, K_ALU, K_SNER, K_LDI, K_JPV, K_RND,
    K_DRW, K_SKP, K_SKNP, K_GDT, K_KEY, K_SDT, K_SST, K_ADDI,
    K_FONT, K_BCD, K_STR, K_LDR, K_TICK, K_MWR, K_MRD, K_SRD
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic        exec_op;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [7:0]  rnd;
    logic [15:0] keys;
    logic        kev;
    logic [3:0]  kidx;
    logic [11:0] addr;
    logic [7:0]  wdata;
  } cmd_t;

  typedef struct packed {
    logic [11:0] pc;
    logic [15:0] index_reg;
    logic [63:0] read_data;
    logic        waiting;
    logic        sound_on;
    logic        collision;
  } res_t;

  function automatic kind_e classify(logic [2:0] func, logic [15:0] ins);
    kind_e k;
    k = K_NOP;
    unique case (func)
      FN_TICK: k = K_TICK;
      FN_MWR:  k = K_MWR;
      FN_MRD:  k = K_MRD;
      FN_SRD:  k = K_SRD;
      FN_EXEC: begin
        unique case (ins[15:12])
          OP_SYS:  k = (ins == INS_CLS) ? K_CLS : (ins == INS_RET) ? K_RET : K_NOP;
          OP_JP:   k = K_JP;
          OP_CALL: k = K_CALL;
          OP_SEI:  k = K_SEI;
          OP_SNEI: k = K_SNEI;
          OP_SER:  k = (ins[3:0] == 4'h0) ? K_SER : K_NOP;
          OP_LDK:  k = K_LDK;
          OP_ADDK: k = K_ADDK;
          OP_ALU:  k = (ins[3] == 1'b0 || ins[3:0] == ALU_SHL) ? K_ALU : K_NOP;
          OP_SNER: k = (ins[3:0] == 4'h0) ? K_SNER : K_NOP;
          OP_LDI:  k = K_LDI;
          OP_JPV:  k = K_JPV;
          OP_RND:  k = K_RND;
          OP_DRW:  k = K_DRW;
          OP_KEYS: k = (ins[7:0] == SUB_SKP) ? K_SKP :
                       (ins[7:0] == SUB_SKNP) ? K_SKNP : K_NOP;
          OP_MISC: begin
            unique case (ins[7:0])
              SUB_GDT:  k = K_GDT;
              SUB_KEY:  k = K_KEY;
              SUB_SDT:  k = K_SDT;
              SUB_SST:  k = K_SST;
              SUB_ADDI: k = K_ADDI;
              SUB_FONT: k = K_FONT;
              SUB_BCD:  k = K_BCD;
              SUB_STR:  k = K_STR;
              SUB_LDR:  k = K_LDR;
              default:  k = K_NOP;
            endcase
          end
          default: k = K_NOP;
        endcase
      end
      default: k = K_IGN;
    endcase
    return k;
  endfunction

endpackage

@@ sv/c8x_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module c8x_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/c8x_front.sv @@
`timescale 1ns / 1ps
// Front end: takes input items, classifies them and holds them in a two-entry queue.
// Depends on c8x_pkg.
module c8x_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [2:0]    func_i,
  input  logic [15:0]   instruction_i,
  input  logic [7:0]    random_byte_i,
  input  logic [15:0]   keys_down_i,
  input  logic          key_event_valid_i,
  input  logic [3:0]    key_event_index_i,
  input  logic [11:0]   address_i,
  input  logic [7:0]    write_data_i,
  output logic          cmd_valid_o,
  output c8x_pkg::cmd_t cmd_o,
  input  logic          cmd_ready_i
);
  import c8x_pkg::*;

  cmd_t       q_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_in;
  logic       wr, rd;

  always_comb begin
    cmd_in.kind    = classify(func_i, instruction_i);
    cmd_in.exec_op = (func_i == FN_EXEC);
    cmd_in.x       = instruction_i[11:8];
    cmd_in.y       = instruction_i[7:4];
    cmd_in.n       = instruction_i[3:0];
    cmd_in.kk      = instruction_i[7:0];
    cmd_in.nnn     = instruction_i[11:0];
    cmd_in.rnd     = random_byte_i;
    cmd_in.keys    = keys_down_i;
    cmd_in.kev     = key_event_valid_i;
    cmd_in.kidx    = key_event_index_i;
    cmd_in.addr    = address_i;
    cmd_in.wdata   = write_data_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rp_q];
  assign wr          = push && !full;
  assign rd          = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      q_q[wp_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

@@ sv/c8x_back.sv @@
`timescale 1ns / 1ps
// Back end: sequencer that carries out one classified item at a time, machine state,
// screen, RAM and a two-entry result queue. Depends on c8x_pkg and c8x_ram.
module c8x_back #(
  parameter int unsigned SCREEN_COLS = c8x_pkg::DEF_COLS,
  parameter int unsigned SCREEN_ROWS = c8x_pkg::DEF_ROWS,
  parameter int unsigned STACK_DEPTH = c8x_pkg::DEF_STACK
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  c8x_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  output logic          empty,
  input  logic          pop,
  output c8x_pkg::res_t res_o
);
  import c8x_pkg::*;

  localparam int unsigned COL_W = $clog2(SCREEN_COLS);
  localparam int unsigned ROW_W = $clog2(SCREEN_ROWS);
  localparam int unsigned SP_W  = $clog2(STACK_DEPTH);
  localparam int unsigned VIS   = (SCREEN_COLS < 64) ? SCREEN_COLS : 64;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_RDX     = 16'h0002,
    S_RDY     = 16'h0004,
    S_EXEC    = 16'h0008,
    S_REDUCE  = 16'h0010,
    S_DRAW_RD = 16'h0020,
    S_DRAW_WR = 16'h0040,
    S_FLAG    = 16'h0080,
    S_BCD100  = 16'h0100,
    S_BCD10   = 16'h0200,
    S_BCDW    = 16'h0400,
    S_STORE   = 16'h0800,
    S_LOAD_RD = 16'h1000,
    S_LOAD_WB = 16'h2000,
    S_MRD     = 16'h4000,
    S_DONE    = 16'h8000
  } state_e;

  state_e            state_q, state_d;
  cmd_t              cmd_q;
  logic [7:0]        a_q, b_q;
  logic [7:0]        vregs_q [16];
  logic [15:0]       idx_q;
  logic [11:0]       pc_q;
  logic [11:0]       stack_q [STACK_DEPTH];
  logic [SP_W-1:0]   sp_q;
  logic [7:0]        dt_q, st_q;
  logic [SCREEN_COLS-1:0] frame_q [SCREEN_ROWS];
  logic [7:0]        px_q, py_q;
  logic [3:0]        cnt_q;
  logic              hit_q, flag_q;
  logic [7:0]        val_q;
  logic [1:0]        hund_q;
  logic [3:0]        tens_q;
  logic [63:0]       rdat_q;
  logic              wait_q, coll_q;

  res_t              rq_q [2];
  logic              rq_wp_q, rq_rp_q;
  logic [1:0]        rq_cnt_q;

  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr, ram_raddr, ram_base;
  logic [7:0]        ram_wdata, ram_rdata;
  logic [3:0]        vr_addr;
  logic [7:0]        vr_data;
  logic [SCREEN_COLS-1:0] mask, row_sel, srow;
  logic [8:0]        col;
  logic              row_hit, px_big, py_big, draw_last;
  logic [7:0]        alu_res;
  logic [8:0]        sum9;
  logic              alu_flag, alu_wf;
  logic [11:0]       pc_inc, pc_skip;
  logic [SP_W-1:0]   sp_inc, sp_dec;
  logic              rq_push, rq_pop;
  res_t              res_new;

  assign pc_inc   = pc_q + 12'd2;
  assign pc_skip  = pc_q + 12'd4;
  assign sp_inc   = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + SP_W'(1);
  assign sp_dec   = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - SP_W'(1);
  assign ram_base = idx_q[MEM_AW-1:0] + {{(MEM_AW-4){1'b0}}, cnt_q};
  assign vr_data  = vregs_q[vr_addr];
  assign row_sel  = frame_q[py_q[ROW_W-1:0]];
  assign srow     = frame_q[cmd_q.addr[ROW_W-1:0]];
  assign row_hit  = |(row_sel & mask);
  assign px_big   = ({1'b0, px_q} >= 9'(SCREEN_COLS));
  assign py_big   = ({1'b0, py_q} >= 9'(SCREEN_ROWS));
  assign draw_last = ({1'b0, cnt_q} + 5'd1 == {1'b0, cmd_q.n});

  always_comb begin
    unique case (state_q)
      S_RDX:   vr_addr = cmd_q.x;
      S_RDY:   vr_addr = (cmd_q.kind == K_JPV) ? 4'h0 : cmd_q.y;
      default: vr_addr = cnt_q;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ram_base;
    ram_wdata = vr_data;
    ram_raddr = ram_base;
    if (state_q == S_EXEC && cmd_q.kind == K_MWR) begin
      ram_we    = 1'b1;
      ram_waddr = cmd_q.addr;
      ram_wdata = cmd_q.wdata;
    end
    if (state_q == S_EXEC && cmd_q.kind == K_MRD) begin
      ram_raddr = cmd_q.addr;
    end
    if (state_q == S_STORE) begin
      ram_we = 1'b1;
    end
    if (state_q == S_BCDW) begin
      ram_we    = 1'b1;
      ram_wdata = (cnt_q == 4'd0) ? {6'b0, hund_q} :
                  (cnt_q == 4'd1) ? {4'b0, tens_q} : val_q;
    end
  end

  c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // sprite byte spread over the row, wrapping at the right edge
  always_comb begin
    mask = '0;
    col  = '0;
    for (int c = 0; c < 8; c++) begin
      col = {1'b0, px_q} + 9'(c);
      if (col >= 9'(SCREEN_COLS)) col = col - 9'(SCREEN_COLS);
      if (ram_rdata[7-c]) mask[col[COL_W-1:0]] = 1'b1;
    end
  end

  always_comb begin
    sum9     = {1'b0, a_q} + {1'b0, b_q};
    alu_res  = a_q;
    alu_flag = 1'b0;
    alu_wf   = 1'b1;
    unique case (cmd_q.n)
      ALU_LD:   begin alu_res = b_q;       alu_wf = 1'b0; end
      ALU_OR:   begin alu_res = a_q | b_q; alu_wf = 1'b0; end
      ALU_AND:  begin alu_res = a_q & b_q; alu_wf = 1'b0; end
      ALU_XOR:  begin alu_res = a_q ^ b_q; alu_wf = 1'b0; end
      ALU_ADD:  begin alu_res = sum9[7:0]; alu_flag = sum9[8]; end
      ALU_SUB:  begin alu_res = a_q - b_q; alu_flag = (a_q >= b_q); end
      ALU_SHR:  begin alu_res = a_q >> 1;  alu_flag = a_q[0]; end
      ALU_SUBN: begin alu_res = b_q - a_q; alu_flag = (b_q >= a_q); end
      ALU_SHL:  begin alu_res = a_q << 1;  alu_flag = a_q[7]; end
      default:  alu_wf = 1'b0;
    endcase
  end

  assign cmd_ready_o = (state_q == S_IDLE) && (rq_cnt_q != 2'd2);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (cmd_valid_i && rq_cnt_q != 2'd2) state_d = S_RDX;
      S_RDX:    state_d = S_RDY;
      S_RDY:    state_d = S_EXEC;
      S_EXEC: begin
        unique case (cmd_q.kind)
          K_ALU:   state_d = alu_wf ? S_FLAG : S_DONE;
          K_DRW:   state_d = S_REDUCE;
          K_BCD:   state_d = S_BCD100;
          K_STR:   state_d = S_STORE;
          K_LDR:   state_d = S_LOAD_RD;
          K_MRD:   state_d = S_MRD;
          default: state_d = S_DONE;
        endcase
      end
      S_REDUCE: if (!px_big && !py_big) state_d = (cmd_q.n == 4'd0) ? S_FLAG : S_DRAW_RD;
      S_DRAW_RD: state_d = S_DRAW_WR;
      S_DRAW_WR: state_d = draw_last ? S_FLAG : S_DRAW_RD;
      S_FLAG:    state_d = S_DONE;
      S_BCD100:  if (val_q < 8'd100) state_d = S_BCD10;
      S_BCD10:   if (val_q < 8'd10) state_d = S_BCDW;
      S_BCDW:    if (cnt_q == 4'd2) state_d = S_DONE;
      S_STORE:   if (cnt_q == cmd_q.x) state_d = S_DONE;
      S_LOAD_RD: state_d = S_LOAD_WB;
      S_LOAD_WB: state_d = (cnt_q == cmd_q.x) ? S_DONE : S_LOAD_RD;
      S_MRD:     state_d = S_DONE;
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
      vregs_q <= '{default: '0};
      idx_q   <= '0;
      pc_q    <= PC_RESET;
      stack_q <= '{default: '0};
      sp_q    <= '0;
      dt_q    <= '0;
      st_q    <= '0;
      frame_q <= '{default: '0};
      px_q    <= '0;
      py_q    <= '0;
      cnt_q   <= '0;
      hit_q   <= 1'b0;
      flag_q  <= 1'b0;
      val_q   <= '0;
      hund_q  <= '0;
      tens_q  <= '0;
      rdat_q  <= '0;
      wait_q  <= 1'b0;
      coll_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: if (cmd_ready_o && cmd_valid_i) cmd_q <= cmd_i;
        S_RDX: begin
          a_q    <= vr_data;
          rdat_q <= '0;
          wait_q <= 1'b0;
          coll_q <= 1'b0;
        end
        S_RDY: b_q <= vr_data;
        S_EXEC: begin
          if (cmd_q.exec_op) pc_q <= pc_inc;
          unique case (cmd_q.kind)
            K_CLS:  frame_q <= '{default: '0};
            K_RET: begin
              sp_q <= sp_dec;
              pc_q <= stack_q[sp_dec];
            end
            K_JP:   pc_q <= cmd_q.nnn;
            K_CALL: begin
              stack_q[sp_q] <= pc_inc;
              sp_q          <= sp_inc;
              pc_q          <= cmd_q.nnn;
            end
            K_SEI:  pc_q <= (a_q == cmd_q.kk) ? pc_skip : pc_inc;
            K_SNEI: pc_q <= (a_q != cmd_q.kk) ? pc_skip : pc_inc;
            K_SER:  pc_q <= (a_q == b_q) ? pc_skip : pc_inc;
            K_SNER: pc_q <= (a_q != b_q) ? pc_skip : pc_inc;
            K_SKP:  pc_q <= cmd_q.keys[a_q[3:0]] ? pc_skip : pc_inc;
            K_SKNP: pc_q <= cmd_q.keys[a_q[3:0]] ? pc_inc : pc_skip;
            K_LDK:  vregs_q[cmd_q.x] <= cmd_q.kk;
            K_ADDK: vregs_q[cmd_q.x] <= a_q + cmd_q.kk;
            K_ALU: begin
              vregs_q[cmd_q.x] <= alu_res;
              flag_q           <= alu_flag;
            end
            K_LDI:  idx_q <= {4'b0, cmd_q.nnn};
            K_JPV:  pc_q <= cmd_q.nnn + {4'b0, b_q};
            K_RND:  vregs_q[cmd_q.x] <= cmd_q.rnd & cmd_q.kk;
            K_DRW: begin
              px_q   <= a_q;
              py_q   <= b_q;
              cnt_q  <= '0;
              hit_q  <= 1'b0;
              flag_q <= 1'b0;
            end
            K_GDT:  vregs_q[cmd_q.x] <= dt_q;
            K_KEY: begin
              if (cmd_q.kev) begin
                vregs_q[cmd_q.x] <= {4'b0, cmd_q.kidx};
              end else begin
                pc_q   <= pc_q;
                wait_q <= 1'b1;
              end
            end
            K_SDT:  dt_q <= a_q;
            K_SST:  st_q <= a_q;
            K_ADDI: idx_q <= idx_q + {8'b0, a_q};
            K_FONT: idx_q <= FONT_BASE + {10'b0, a_q[3:0], 2'b00} + {12'b0, a_q[3:0]};
            K_BCD: begin
              val_q  <= a_q;
              hund_q <= '0;
              tens_q <= '0;
            end
            K_STR:  cnt_q <= '0;
            K_LDR:  cnt_q <= '0;
            K_TICK: begin
              if (st_q != 8'd0) st_q <= st_q - 8'd1;
              if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
            end
            K_SRD: begin
              if (cmd_q.addr < 12'(SCREEN_ROWS)) rdat_q <= 64'(srow[VIS-1:0]);
            end
            default: ;
          endcase
        end
        S_REDUCE: begin
          if (px_big) begin
            px_q <= px_q - 8'(SCREEN_COLS);
          end else if (py_big) begin
            py_q <= py_q - 8'(SCREEN_ROWS);
          end
        end
        S_DRAW_WR: begin
          frame_q[py_q[ROW_W-1:0]] <= row_sel ^ mask;
          hit_q <= hit_q | row_hit;
          cnt_q <= cnt_q + 4'd1;
          py_q  <= ({1'b0, py_q} + 9'd1 == 9'(SCREEN_ROWS)) ? '0 : py_q + 8'd1;
          if (draw_last) begin
            flag_q <= hit_q | row_hit;
            coll_q <= hit_q | row_hit;
          end
        end
        S_FLAG: vregs_q[15] <= {7'b0, flag_q};
        S_BCD100: begin
          if (val_q >= 8'd100) begin
            val_q  <= val_q - 8'd100;
            hund_q <= hund_q + 2'd1;
          end
        end
        S_BCD10: begin
          if (val_q >= 8'd10) begin
            val_q  <= val_q - 8'd10;
            tens_q <= tens_q + 4'd1;
          end else begin
            cnt_q <= '0;
          end
        end
        S_BCDW:    cnt_q <= cnt_q + 4'd1;
        S_STORE:   cnt_q <= cnt_q + 4'd1;
        S_LOAD_WB: begin
          vregs_q[cnt_q] <= ram_rdata;
          cnt_q          <= cnt_q + 4'd1;
        end
        S_MRD:     rdat_q <= {56'b0, ram_rdata};
        default: ;
      endcase
    end
  end

  assign rq_push = (state_q == S_DONE);
  assign rq_pop  = pop && !empty;
  assign empty   = (rq_cnt_q == 2'd0);
  assign res_o   = rq_q[rq_rp_q];

  always_comb begin
    res_new.pc        = pc_q;
    res_new.index_reg = idx_q;
    res_new.read_data = rdat_q;
    res_new.waiting   = wait_q;
    res_new.sound_on  = (st_q != 8'd0);
    res_new.collision = coll_q;
  end

  always_ff @(posedge clk_i) begin
    if (rq_push) begin
      rq_q[rq_wp_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wp_q  <= 1'b0;
      rq_rp_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      if (rq_push) rq_wp_q <= ~rq_wp_q;
      if (rq_pop)  rq_rp_q <= ~rq_rp_q;
      rq_cnt_q <= rq_cnt_q + {1'b0, rq_push} - {1'b0, rq_pop};
    end
  end

endmodule

@@ sv/chip8_instruction_execute_top.sv @@
`timescale 1ns / 1ps
// Channel   | Handshake            | Payload
// input     | push / full          | func, instruction, random_byte, keys_down,
//           |                      | key event, address, write_data
// result    | empty / pop          | pc, index_reg, read_data, waiting_for_key, sound_on, collision
//
// One item in flight in the back end; every item passes RDX, RDY, EXEC and DONE on its way
// from queue head to result, an 8xy_ that writes VF adds FLAG and a RAM byte read adds MRD.
// Dxyn adds coordinate wrap in REDUCE (64x32 screen by default), a read and a write per sprite row and FLAG for VF;
// Fx33 adds the BCD steps, Fx55 a store per register and Fx65 a read and a write-back per register.
// Reset clears registers, stack and screen at once; RAM holds no data until written.
// Two-entry queues on both sides keep input and result stalls apart.
// Top level of the CHIP-8 executor. Depends on c8x_pkg, c8x_front, c8x_back.
module chip8_instruction_execute_top #(
  parameter int unsigned SCREEN_COLS = c8x_pkg::DEF_COLS,
  parameter int unsigned SCREEN_ROWS = c8x_pkg::DEF_ROWS,
  parameter int unsigned STACK_DEPTH = c8x_pkg::DEF_STACK
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  func_i,
  input  logic [15:0] instruction_i,
  input  logic [7:0]  random_byte_i,
  input  logic [15:0] keys_down_i,
  input  logic        key_event_valid_i,
  input  logic [3:0]  key_event_index_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] pc_o,
  output logic [15:0] index_reg_o,
  output logic [63:0] read_data_o,
  output logic        waiting_for_key_o,
  output logic        sound_on_o,
  output logic        collision_o
);
  import c8x_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  c8x_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .func_i           (func_i),
    .instruction_i    (instruction_i),
    .random_byte_i    (random_byte_i),
    .keys_down_i      (keys_down_i),
    .key_event_valid_i(key_event_valid_i),
    .key_event_index_i(key_event_index_i),
    .address_i        (address_i),
    .write_data_i     (write_data_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_ready_i      (cmd_ready)
  );

  c8x_back #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_ready_o(cmd_ready),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res)
  );

  assign pc_o              = res.pc;
  assign index_reg_o       = res.index_reg;
  assign read_data_o       = res.read_data;
  assign waiting_for_key_o = res.waiting;
  assign sound_on_o        = res.sound_on;
  assign collision_o       = res.collision;

endmodule

@@ sv/c8x_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the CHIP-8 executor, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module c8x_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [11:0] pc_o,
  input logic [15:0] index_reg_o,
  input logic [63:0] read_data_o,
  input logic        waiting_for_key_o,
  input logic        collision_o
);

  `ASSERT_PROP(a_res_hold, (!empty && !pop) |=> (empty || $stable(pc_o)), "result not held")
  `ASSERT_PROP(a_idx_hold, (!empty && !pop) |=> (empty || $stable(index_reg_o)), "index not held")
  `ASSERT_NEVER(a_wait_draw, !empty && waiting_for_key_o && collision_o, "key wait with draw")
  `ASSERT_NEVER(a_wait_data, !empty && waiting_for_key_o && |read_data_o, "key wait with data")
  `ASSERT_NEVER(a_draw_data, !empty && collision_o && |read_data_o, "draw with read data")

endmodule

bind chip8_instruction_execute_top c8x_checker u_chk (.*);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for chip8_instruction_execute_top: directed and random
// instruction streams, checked against a behavioral CHIP-8 machine model.
// Depends on c8x_pkg and the executor RTL.
module tb;
  import c8x_pkg::*;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] ins;
    logic [7:0]  rnd;
    logic [15:0] keys;
    logic        kev;
    logic [3:0]  kidx;
    logic [11:0] addr;
    logic [7:0]  wdata;
  } item_t;

  class chip8_scoreboard;
    logic [7:0]  ram [MEM_BYTES];
    bit          ram_ok [MEM_BYTES];
    logic [63:0] frame [DEF_ROWS];
    logic [7:0]  v [16];
    logic [15:0] idx;
    logic [11:0] pc;
    logic [11:0] stk [DEF_STACK];
    logic [3:0]  sp;
    logic [7:0]  dt, st;
    res_t        expected_q [$];
    int          errors;

    function new();
      for (int i = 0; i < MEM_BYTES; i++) begin
        ram[i] = 8'h00;
        ram_ok[i] = 0;
      end
      foreach (frame[r]) frame[r] = '0;
      foreach (v[i]) v[i] = '0;
      foreach (stk[i]) stk[i] = '0;
      idx = '0;
      pc = PC_RESET;
      sp = '0;
      dt = '0;
      st = '0;
      errors = 0;
    endfunction

    // RAM bytes the item would read that were never written
    function void missing_bytes(item_t it, ref int unsigned q[$]);
      int cnt;
      cnt = 0;
      q.delete();
      if (it.func == FN_MRD && !ram_ok[it.addr]) q.push_back(it.addr);
      if (it.func == FN_EXEC) begin
        if (it.ins[15:12] == OP_DRW) cnt = it.ins[3:0];
        else if (it.ins[15:12] == OP_MISC && it.ins[7:0] == SUB_LDR) cnt = it.ins[11:8] + 1;
        for (int k = 0; k < cnt; k++)
          if (!ram_ok[(idx + k) % MEM_BYTES]) q.push_back((idx + k) % MEM_BYTES);
      end
    endfunction

    function void put_ram(int unsigned a, logic [7:0] d);
      ram[a % MEM_BYTES] = d;
      ram_ok[a % MEM_BYTES] = 1;
    endfunction

    function void run_alu(logic [3:0] x, logic [3:0] y, logic [3:0] op);
      logic [8:0] a, b, res;
      logic flag;
      a = v[x];
      b = v[y];
      case (op)
        ALU_LD:  begin v[x] = b[7:0]; return; end
        ALU_OR:  begin v[x] = a[7:0] | b[7:0]; return; end
        ALU_AND: begin v[x] = a[7:0] & b[7:0]; return; end
        ALU_XOR: begin v[x] = a[7:0] ^ b[7:0]; return; end
        ALU_ADD: begin res = a + b; flag = res[8]; end
        ALU_SUB: begin res = a - b; flag = a >= b; end
        ALU_SHR: begin res = a >> 1; flag = a[0]; end
        ALU_SUBN: begin res = b - a; flag = b >= a; end
        ALU_SHL: begin res = a << 1; flag = a[7]; end
        default: return;
      endcase
      v[x] = res[7:0];
      v[15] = {7'd0, flag};
    endfunction

    function void note_item(item_t it);
      res_t r;
      logic [3:0] x, y, n;
      logic [7:0] kk, bits;
      logic [11:0] nnn;
      int py, px;
      r = '0;
      x = it.ins[11:8];
      y = it.ins[7:4];
      n = it.ins[3:0];
      kk = it.ins[7:0];
      nnn = it.ins[11:0];
      case (it.func)
        FN_EXEC: begin
          pc = pc + 12'd2;
          case (it.ins[15:12])
            OP_SYS: begin
              if (it.ins == INS_CLS) foreach (frame[i]) frame[i] = '0;
              else if (it.ins == INS_RET) begin
                sp = sp - 4'd1;
                pc = stk[sp];
              end
            end
            OP_JP: pc = nnn;
            OP_CALL: begin
              stk[sp] = pc;
              sp = sp + 4'd1;
              pc = nnn;
            end
            OP_SEI:  if (v[x] == kk) pc = pc + 12'd2;
            OP_SNEI: if (v[x] != kk) pc = pc + 12'd2;
            OP_SER:  if (n == 4'h0 && v[x] == v[y]) pc = pc + 12'd2;
            OP_LDK:  v[x] = kk;
            OP_ADDK: v[x] = v[x] + kk;
            OP_ALU:  run_alu(x, y, n);
            OP_SNER: if (n == 4'h0 && v[x] != v[y]) pc = pc + 12'd2;
            OP_LDI:  idx = {4'h0, nnn};
            OP_JPV:  pc = nnn + {4'h0, v[0]};
            OP_RND:  v[x] = it.rnd & kk;
            OP_DRW: begin
              for (int k = 0; k < n; k++) begin
                bits = ram[(idx + k) % MEM_BYTES];
                py = (v[y] + k) % DEF_ROWS;
                for (int c = 0; c < 8; c++)
                  if (bits[7 - c]) begin
                    px = (v[x] + c) % DEF_COLS;
                    if (frame[py][px]) r.collision = 1'b1;
                    frame[py][px] = ~frame[py][px];
                  end
              end
              v[15] = {7'd0, r.collision};
            end
            OP_KEYS: begin
              if (kk == SUB_SKP && it.keys[v[x][3:0]]) pc = pc + 12'd2;
              else if (kk == SUB_SKNP && !it.keys[v[x][3:0]]) pc = pc + 12'd2;
            end
            default: begin
              case (kk)
                SUB_GDT: v[x] = dt;
                SUB_KEY: begin
                  if (it.kev) v[x] = {4'h0, it.kidx};
                  else begin
                    pc = pc - 12'd2;
                    r.waiting = 1'b1;
                  end
                end
                SUB_SDT:  dt = v[x];
                SUB_SST:  st = v[x];
                SUB_ADDI: idx = idx + {8'h0, v[x]};
                SUB_FONT: idx = FONT_BASE + 16'd5 * v[x][3:0];
                SUB_BCD: begin
                  put_ram(idx, 8'(v[x] / 100));
                  put_ram(idx + 1, 8'((v[x] / 10) % 10));
                  put_ram(idx + 2, 8'(v[x] % 10));
                end
                SUB_STR: for (int i = 0; i <= x; i++) put_ram(idx + i, v[i]);
                SUB_LDR: for (int i = 0; i <= x; i++) v[i] = ram[(idx + i) % MEM_BYTES];
                default: ;
              endcase
            end
          endcase
        end
        FN_TICK: begin
          if (st != 0) st = st - 8'd1;
          if (dt != 0) dt = dt - 8'd1;
        end
        FN_MWR: put_ram(it.addr, it.wdata);
        FN_MRD: r.read_data = {56'd0, ram[it.addr]};
        FN_SRD: if (it.addr < DEF_ROWS) r.read_data = frame[it.addr];
        default: ;
      endcase
      r.pc = pc;
      r.index_reg = idx;
      r.sound_on = st != 0;
      expected_q.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result pc=%h", $time, got.pc);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.pc !== e.pc)
        $display("%0t: pc exp %h got %h", $time, e.pc, got.pc);
      if (got.index_reg !== e.index_reg)
        $display("%0t: index_reg exp %h got %h", $time, e.index_reg, got.index_reg);
      if (got.read_data !== e.read_data)
        $display("%0t: read_data exp %h got %h", $time, e.read_data, got.read_data);
      if (got.waiting !== e.waiting)
        $display("%0t: waiting_for_key exp %b got %b", $time, e.waiting, got.waiting);
      if (got.sound_on !== e.sound_on)
        $display("%0t: sound_on exp %b got %b", $time, e.sound_on, got.sound_on);
      if (got.collision !== e.collision)
        $display("%0t: collision exp %b got %b", $time, e.collision, got.collision);
      if (got !== e) errors++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty;
  logic [2:0]  func_i = '0;
  logic [15:0] instruction_i = '0;
  logic [7:0]  random_byte_i = '0;
  logic [15:0] keys_down_i = '0;
  logic        key_event_valid_i = 1'b0;
  logic [3:0]  key_event_index_i = '0;
  logic [11:0] address_i = '0;
  logic [7:0]  write_data_i = '0;
  logic [11:0] pc_o;
  logic [15:0] index_reg_o;
  logic [63:0] read_data_o;
  logic        waiting_for_key_o, sound_on_o, collision_o;

  chip8_scoreboard sb = new();
  bit quiet = 0;
  bit timed_out = 0;

  always #2 clk_i = ~clk_i;

  chip8_instruction_execute_top dut (.*);

  // one transfer; applies a random gap first unless in the quiet phase
  task automatic push_raw(item_t it);
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    func_i <= it.func;
    instruction_i <= it.ins;
    random_byte_i <= it.rnd;
    keys_down_i <= it.keys;
    key_event_valid_i <= it.kev;
    key_event_index_i <= it.kidx;
    address_i <= it.addr;
    write_data_i <= it.wdata;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_item(it);
  endtask

  function automatic item_t rand_item(logic [2:0] f);
    item_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    it.func = f;
    return it;
  endfunction

  // backfills unwritten RAM the item would read, then sends it
  task automatic send(item_t it);
    int unsigned need [$];
    item_t w;
    sb.missing_bytes(it, need);
    foreach (need[i]) begin
      w = rand_item(FN_MWR);
      w.addr = need[i];
      push_raw(w);
    end
    push_raw(it);
  endtask

  task automatic exec(logic [15:0] ins, logic kev = 1'b0);
    item_t it;
    it = rand_item(FN_EXEC);
    it.ins = ins;
    it.kev = kev;
    send(it);
  endtask

  task automatic read_row(logic [11:0] row);
    item_t it;
    it = rand_item(FN_SRD);
    it.addr = row;
    send(it);
  endtask

  function automatic logic [15:0] rand_word();
    logic [3:0] x, y;
    logic [3:0] alu_ops [9] = '{ALU_LD, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB,
                                 ALU_SHR, ALU_SUBN, ALU_SHL};
    logic [7:0] misc [11] = '{SUB_GDT, SUB_KEY, SUB_SDT, SUB_SST, SUB_ADDI, SUB_FONT,
                              SUB_BCD, SUB_STR, SUB_LDR, SUB_GDT, SUB_SDT};
    x = 4'($urandom);
    y = 4'($urandom);
    case ($urandom_range(0, 21))
      0:  return 16'($urandom);
      1:  return ($urandom_range(0, 3) == 0) ? INS_CLS : {OP_SYS, 12'($urandom)};
      2:  return INS_RET;
      3:  return {OP_JP, 12'($urandom)};
      4:  return {OP_CALL, 12'($urandom)};
      5:  return {OP_SEI, x, ($urandom_range(0, 1) ? sb.v[x] : 8'($urandom))};
      6:  return {OP_SNEI, x, ($urandom_range(0, 1) ? sb.v[x] : 8'($urandom))};
      7:  return {OP_SER, x, y, 4'h0};
      8:  return {OP_LDK, x, 8'($urandom)};
      9:  return {OP_ADDK, x, 8'($urandom)};
      10, 11: return {OP_ALU, x, y, ($urandom_range(0, 9) == 0) ? 4'($urandom)
                                     : alu_ops[$urandom_range(0, 8)]};
      12: return {OP_SNER, x, y, ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'h0};
      13: return {OP_LDI, 12'($urandom)};
      14: return {OP_JPV, 12'($urandom)};
      15: return {OP_RND, x, 8'($urandom)};
      16, 17: return {OP_DRW, x, y, ($urandom_range(0, 9) == 0) ? 4'($urandom)
                                     : 4'($urandom_range(0, 5))};
      18: return {OP_KEYS, x, ($urandom_range(0, 1) ? SUB_SKP : SUB_SKNP)};
      default: return {OP_MISC, x, ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                  : misc[$urandom_range(0, 10)]};
    endcase
  endfunction

  initial begin : stimulus
    item_t it;
    int sel;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    exec(INS_RET);                    // stack underflow wraps
    exec({OP_CALL, 12'hFFE});
    exec({OP_SYS, 12'h123});
    exec({OP_LDK, 4'h0, 8'hFF});
    exec({OP_LDK, 4'hF, 8'h01});
    exec({OP_ALU, 4'hF, 4'h0, ALU_ADD}); // flag lands in VF last
    exec({OP_ALU, 4'h0, 4'h0, ALU_SUB}); // equal operands, no borrow
    exec({OP_ALU, 4'h1, 4'h0, ALU_SUBN});
    exec({OP_LDK, 4'h2, 8'hFF});
    exec({OP_ALU, 4'h2, 4'h2, ALU_SHL});
    exec({OP_SER, 4'h1, 4'h2, 4'h1});
    exec({OP_MISC, 4'h2, SUB_FONT});
    exec({OP_MISC, 4'h2, SUB_BCD});
    exec({OP_LDK, 4'h3, 8'd63});
    exec({OP_LDK, 4'h4, 8'd31});
    exec({OP_LDI, 12'hFFE});
    exec({OP_DRW, 4'h3, 4'h4, 4'hF});  // wraps columns, rows and RAM
    exec({OP_DRW, 4'h3, 4'h4, 4'h3});  // redraw: collision
    read_row(12'd31);
    read_row(12'd32);
    exec({OP_MISC, 4'hF, SUB_STR});
    exec({OP_MISC, 4'hF, SUB_LDR});
    exec({OP_MISC, 4'h5, SUB_KEY}, 1'b0);
    exec({OP_MISC, 4'h5, SUB_KEY}, 1'b1);
    exec({OP_JPV, 12'hFFF});
    send(rand_item(3'd7));

    for (int n = 0; n < 560; n++) begin
      if (n == 480) quiet = 1;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        it = rand_item(FN_EXEC);
        it.ins = rand_word();
        it.kev = $urandom_range(0, 2) != 0;
      end else if (sel < 78) it = rand_item(FN_TICK);
      else if (sel < 86) it = rand_item(FN_MWR);
      else if (sel < 92) it = rand_item(FN_MRD);
      else begin
        it = rand_item(FN_SRD);
        if ($urandom_range(0, 7) != 0) it.addr = 12'($urandom_range(0, 40));
      end
      if ($urandom_range(0, 49) == 0) it.func = 3'($urandom_range(5, 7));
      send(it);
    end
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && !timed_out) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin : result_side
    res_t got;
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got.pc = pc_o;
        got.index_reg = index_reg_o;
        got.read_data = read_data_o;
        got.waiting = waiting_for_key_o;
        got.sound_on = sound_on_o;
        got.collision = collision_o;
        sb.check_result(got);
      end
      if (!quiet && burst == 0 && $urandom_range(0, 7) == 0) burst = $urandom_range(1, 14);
      if (burst > 0 && !quiet) begin
        burst--;
        pop <= 1'b0;
      end else begin
        burst = 0;
        pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #20ms;
    timed_out = 1;
    $display("== FAIL ==");
    $finish;
  end
endmodule
